/* hdl/linear_regressor_bank_clamped_macros.svh */
// assertion helpers for the regressor bank
`ifndef LINEAR_REGRESSOR_BANK_CLAMPED_MACROS_SVH
`define LINEAR_REGRESSOR_BANK_CLAMPED_MACROS_SVH

// same-cycle implication
`define LRB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("regressor bank check failed");

// next-cycle implication
`define LRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("regressor bank check failed");

`endif

/* hdl/lrb_pkg.sv */
package lrb_pkg;

   // request kinds
   localparam logic [1:0] KIND_WEIGHT = 2'd0;
   localparam logic [1:0] KIND_BIAS   = 2'd1;
   localparam logic [1:0] KIND_SAMPLE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_ACTIVE_OUTPUTS  = 2'd0;
   localparam logic [1:0] CSR_ACTIVE_FEATURES = 2'd1;

   localparam logic [6:0]  ACTIVE_OUTPUTS_RESET  = 7'd0;
   localparam logic [12:0] ACTIVE_FEATURES_RESET = 13'd4096;

   localparam logic [10:0] PRED_MAX = 11'd1280;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic [6:0]  active_outputs;
      logic [12:0] active_features;
   } cfg_type;

   // classified request; data is the weight, the bias or element minus median
   typedef struct packed {
      logic [1:0]         kind;
      logic [11:0]        feat;
      logic [5:0]         oidx;
      logic signed [16:0] data;
      logic               use_feat;
      logic               last;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qout_type;

   typedef struct packed {
      logic        valid;
      logic [10:0] prediction;
      logic [5:0]  regressor_index;
      logic        last;
   } rsp_type;

endpackage

/* hdl/lrb_front.sv */
module lrb_front #(
   parameter int MAX_FEATURES = 4096,
   parameter int MAX_OUTPUTS  = 16
) (
   input  logic                start,
   input  logic                full,
   input  logic [1:0]          req_kind,
   input  logic [11:0]         req_feature_index,
   input  logic [5:0]          req_output_index,
   input  logic signed [15:0]  req_value,
   input  logic signed [15:0]  req_median_value,
   input  logic                req_last_element,
   input  lrb_pkg::cfg_type    cfg,
   output logic                push,
   output lrb_pkg::cmd_type    push_cmd
);

   logic feat_in_range;
   logic oidx_in_range;
   logic feat_used;
   logic keep;

   assign feat_in_range = 32'(req_feature_index) < MAX_FEATURES;
   assign oidx_in_range = 32'(req_output_index) < MAX_OUTPUTS;
   assign feat_used     = feat_in_range && (13'(req_feature_index) < cfg.active_features);

   always_comb begin
      push_cmd.kind     = req_kind;
      push_cmd.feat     = req_feature_index;
      push_cmd.oidx     = req_output_index;
      push_cmd.use_feat = feat_used;
      push_cmd.last     = req_last_element;
      push_cmd.data     = 17'(req_value);
      keep              = 1'b0;
      case (req_kind)
         lrb_pkg::KIND_WEIGHT: begin
            keep = feat_in_range && oidx_in_range;
         end
         lrb_pkg::KIND_BIAS: begin
            keep = oidx_in_range;
         end
         lrb_pkg::KIND_SAMPLE: begin
            push_cmd.data = 17'(req_value) - 17'(req_median_value);
            // unused element still matters when it closes the descriptor
            keep = feat_used || req_last_element;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = start && !full && keep;

endmodule

/* hdl/lrb_queue.sv */
module lrb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lrb_pkg::cmd_type   push_cmd,
   input  logic               pop,
   output logic               full,
   output lrb_pkg::qout_type  qout
);

   localparam int CNT_W = lrb_pkg::QPTR_W + 1;

   lrb_pkg::cmd_type              slot_ff [lrb_pkg::QUEUE_DEPTH];
   logic [lrb_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lrb_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]              count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = lrb_pkg::QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = lrb_pkg::QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full       = count_ff == CNT_W'(lrb_pkg::QUEUE_DEPTH);
   assign qout.valid = count_ff != '0;
   assign qout.cmd   = slot_ff[rd_ptr_ff];

endmodule

/* hdl/lrb_back.sv */
module lrb_back #(
   parameter int MAX_FEATURES = 4096,
   parameter int MAX_OUTPUTS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  lrb_pkg::cfg_type   cfg,
   input  lrb_pkg::qout_type  qout,
   output logic               pop,
   output lrb_pkg::rsp_type   rsp
);

   localparam int OW     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int WDEPTH = MAX_FEATURES * MAX_OUTPUTS;
   localparam int AW     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ACC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   localparam logic signed [36:0] PRED_MAX_W = 37'(lrb_pkg::PRED_MAX);

   logic [15:0]        wmem [WDEPTH];
   logic [47:0]        amem [MAX_OUTPUTS];
   logic [15:0]        bmem [MAX_OUTPUTS];

   logic [1:0]         state_ff, state_in;
   logic [OW-1:0]      idx_ff, idx_in;
   logic [11:0]        cur_feat_ff, cur_feat_in;
   logic signed [16:0] cur_diff_ff, cur_diff_in;
   logic               cur_last_ff, cur_last_in;

   logic [MAX_OUTPUTS-1:0] acc_valid_ff;

   logic               s1_acc_ff, s1_emit_ff, s1_last_ff;
   logic [OW-1:0]      s1_idx_ff;
   logic signed [15:0] w_rd_ff;
   logic signed [47:0] acc_rd_ff;
   logic               accv_ff;
   logic signed [15:0] bias_rd_ff;

   logic               s2_vld_ff;
   logic [OW-1:0]      s2_idx_ff;
   logic signed [47:0] acc_s2_ff;
   logic signed [32:0] prod_s2_ff;

   logic               rsp_valid_ff;
   logic [10:0]        rsp_pred_ff, rsp_pred_in;
   logic [5:0]         rsp_idx_ff;
   logic               rsp_last_ff;

   logic [6:0]         n_eff;
   logic [6:0]         n_last;
   logic               idx_at_end;
   logic               acc_issue, emit_issue, acc_clear;
   logic               wmem_we, bmem_we;
   logic [AW-1:0]      w_waddr, w_raddr;
   logic signed [32:0] prod_in;
   logic signed [47:0] acc_sum;
   logic signed [47:0] acc_e;
   logic signed [35:0] acc_shifted;
   logic signed [36:0] pre_clamp;

   assign n_eff      = (32'(cfg.active_outputs) > MAX_OUTPUTS) ? 7'(MAX_OUTPUTS)
                                                             : cfg.active_outputs;
   assign n_last     = n_eff - 7'd1;
   assign idx_at_end = 7'(idx_ff) == n_last;
   assign pop        = (state_ff == ST_IDLE) && qout.valid;
   assign w_waddr    = AW'(32'(qout.cmd.feat) * MAX_OUTPUTS + 32'(qout.cmd.oidx));
   assign w_raddr    = AW'(32'(cur_feat_ff) * MAX_OUTPUTS + 32'(idx_ff));

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      cur_feat_in = cur_feat_ff;
      cur_diff_in = cur_diff_ff;
      cur_last_in = cur_last_ff;
      acc_issue   = 1'b0;
      emit_issue  = 1'b0;
      acc_clear   = 1'b0;
      wmem_we     = 1'b0;
      bmem_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (qout.valid) begin
               cur_feat_in = qout.cmd.feat;
               cur_diff_in = qout.cmd.data;
               cur_last_in = qout.cmd.last;
               idx_in      = '0;
               case (qout.cmd.kind)
                  lrb_pkg::KIND_WEIGHT: begin
                     wmem_we = 1'b1;
                  end
                  lrb_pkg::KIND_BIAS: begin
                     bmem_we = 1'b1;
                  end
                  lrb_pkg::KIND_SAMPLE: begin
                     if (n_eff == '0) begin
                        acc_clear = qout.cmd.last;
                     end else if (qout.cmd.use_feat) begin
                        state_in = ST_ACC;
                     end else if (qout.cmd.last) begin
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ACC: begin
            acc_issue = 1'b1;
            if (idx_at_end) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = OW'(idx_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            // all accumulator writes must land before the next read
            if (!s1_acc_ff && !s2_vld_ff) begin
               idx_in   = '0;
               state_in = cur_last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            emit_issue = 1'b1;
            if (idx_at_end) begin
               acc_clear = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               idx_in = OW'(idx_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign prod_in = 33'(cur_diff_ff) * 33'(w_rd_ff);
   assign acc_sum = acc_s2_ff + 48'(prod_s2_ff);

   // floor shift, bias, clamp
   assign acc_e       = accv_ff ? acc_rd_ff : '0;
   assign acc_shifted = acc_e[47:12];
   assign pre_clamp   = 37'(acc_shifted) + 37'(bias_rd_ff);

   always_comb begin
      if (pre_clamp[36]) begin
         rsp_pred_in = '0;
      end else if (pre_clamp > PRED_MAX_W) begin
         rsp_pred_in = lrb_pkg::PRED_MAX;
      end else begin
         rsp_pred_in = pre_clamp[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_valid_ff <= '0;
         s1_acc_ff    <= 1'b0;
         s1_emit_ff   <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_acc_ff    <= acc_issue;
         s1_emit_ff   <= emit_issue;
         s2_vld_ff    <= s1_acc_ff;
         rsp_valid_ff <= s1_emit_ff;
         if (acc_clear) begin
            acc_valid_ff <= '0;
         end
         if (s2_vld_ff) begin
            acc_valid_ff[s2_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cur_feat_ff <= cur_feat_in;
      cur_diff_ff <= cur_diff_in;
      cur_last_ff <= cur_last_in;
      s1_idx_ff   <= idx_ff;
      s1_last_ff  <= idx_at_end;
      accv_ff     <= acc_valid_ff[idx_ff];
      s2_idx_ff   <= s1_idx_ff;
      acc_s2_ff   <= accv_ff ? acc_rd_ff : '0;
      prod_s2_ff  <= prod_in;
      rsp_pred_ff <= rsp_pred_in;
      rsp_idx_ff  <= 6'(s1_idx_ff);
      rsp_last_ff <= s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (wmem_we) begin
         wmem[w_waddr] <= qout.cmd.data[15:0];
      end
      w_rd_ff <= wmem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff) begin
         amem[s2_idx_ff] <= acc_sum;
      end
      acc_rd_ff <= amem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (bmem_we) begin
         bmem[qout.cmd.oidx[OW-1:0]] <= qout.cmd.data[15:0];
      end
      bias_rd_ff <= bmem[idx_ff];
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.prediction      = rsp_pred_ff;
   assign rsp.regressor_index = rsp_idx_ff;
   assign rsp.last            = rsp_last_ff;

endmodule

/* hdl/linear_regressor_bank_clamped.sv */
// Bank of clamped linear regressors. Requests enter a four-entry queue and are
// carried out in order by one shared multiply-accumulate with a single weight
// memory read port. A weight or bias load is written as it leaves the queue; a
// used descriptor element is taken from the queue, then gets one weight read per
// regressor, then waits for the pipeline to drain; the element marked last then
// gives one prediction per cycle on rsp_valid, in regressor order, with
// rsp_last_result on the final one. active_outputs above MAX_OUTPUTS counts as
// MAX_OUTPUTS. busy rises only while the queue is full. Results last one cycle
// and cannot be held off: the receiver must take them.
module linear_regressor_bank_clamped #(
   parameter int MAX_FEATURES = 4096,
   parameter int MAX_OUTPUTS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [11:0]        req_feature_index,
   input  logic [5:0]         req_output_index,
   input  logic signed [15:0] req_value,
   input  logic signed [15:0] req_median_value,
   input  logic               req_last_element,
   output logic               rsp_valid,
   output logic [10:0]        rsp_prediction,
   output logic [5:0]         rsp_regressor_index,
   output logic               rsp_last_result,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [12:0]        csr_wdata
);

`include "linear_regressor_bank_clamped_macros.svh"

   lrb_pkg::cfg_type   cfg_ff;
   lrb_pkg::cmd_type   push_cmd;
   lrb_pkg::qout_type  qout;
   lrb_pkg::rsp_type   rsp;
   logic               push;
   logic               pop;
   logic               full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_outputs  <= lrb_pkg::ACTIVE_OUTPUTS_RESET;
         cfg_ff.active_features <= lrb_pkg::ACTIVE_FEATURES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lrb_pkg::CSR_ACTIVE_OUTPUTS: begin
               cfg_ff.active_outputs <= csr_wdata[6:0];
            end
            lrb_pkg::CSR_ACTIVE_FEATURES: begin
               cfg_ff.active_features <= csr_wdata;
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   lrb_front #(
      .MAX_FEATURES (MAX_FEATURES),
      .MAX_OUTPUTS  (MAX_OUTPUTS)
   ) u_front (
      .start             (start),
      .full              (full),
      .req_kind          (req_kind),
      .req_feature_index (req_feature_index),
      .req_output_index  (req_output_index),
      .req_value         (req_value),
      .req_median_value  (req_median_value),
      .req_last_element  (req_last_element),
      .cfg               (cfg_ff),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   lrb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .qout     (qout)
   );

   lrb_back #(
      .MAX_FEATURES (MAX_FEATURES),
      .MAX_OUTPUTS  (MAX_OUTPUTS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .qout  (qout),
      .pop   (pop),
      .rsp   (rsp)
   );

   assign busy                = full;
   assign rsp_valid           = rsp.valid;
   assign rsp_prediction      = rsp.prediction;
   assign rsp_regressor_index = rsp.regressor_index;
   assign rsp_last_result     = rsp.last;

   // a run of predictions is contiguous and starts at regressor zero
   `LRB_ASSERT_IMP(a_run_starts_at_zero, clock, reset, $rose(rsp_valid), rsp_regressor_index == 6'd0)
   `LRB_ASSERT_NEXT(a_run_contiguous, clock, reset, rsp_valid && !rsp_last_result, rsp_valid && (rsp_regressor_index == $past(rsp_regressor_index) + 6'd1))
   `LRB_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_valid && rsp_last_result, !rsp_valid)
   `LRB_ASSERT_IMP(a_no_push_when_full, clock, reset, full, !push)

endmodule

/* tb/sv/linear_regressor_bank_clamped_checker.sv */
module linear_regressor_bank_clamped_checker #(
   parameter int MAX_FEATURES = 4096,
   parameter int MAX_OUTPUTS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [11:0]        req_feature_index,
   input  logic [5:0]         req_output_index,
   input  logic signed [15:0] req_value,
   input  logic signed [15:0] req_median_value,
   input  logic               req_last_element,
   input  logic               rsp_valid,
   input  logic [10:0]        rsp_prediction,
   input  logic [5:0]         rsp_regressor_index,
   input  logic               rsp_last_result,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [12:0]        csr_wdata,
   output int                 errors,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [10:0] prediction;
      logic [5:0]  regressor_index;
      logic        last_result;
   } prediction_type;

   logic signed [15:0] weight_mem [0:MAX_FEATURES*MAX_OUTPUTS-1];
   logic signed [15:0] bias_mem   [0:MAX_OUTPUTS-1];
   logic signed [47:0] acc_mem    [0:MAX_OUTPUTS-1];
   logic [6:0]         active_outputs;
   logic [12:0]        active_features;
   prediction_type     pending_predictions [$];
   prediction_type     oldest;
   int                 mismatch_count = 0;

   assign errors = mismatch_count;

   function automatic int regressors_in_use();
      return (active_outputs > MAX_OUTPUTS) ? MAX_OUTPUTS : int'(active_outputs);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic predict_request(logic [1:0] kind, logic [11:0] feat, logic [5:0] oidx,
                                  logic signed [15:0] value, logic signed [15:0] median,
                                  logic last);
      int             n;
      longint         diff;
      longint         sum;
      prediction_type p;
      n = regressors_in_use();
      case (kind)
         lrb_pkg::KIND_WEIGHT: begin
            if (oidx < MAX_OUTPUTS && feat < MAX_FEATURES)
               weight_mem[feat * MAX_OUTPUTS + oidx] = value;
         end
         lrb_pkg::KIND_BIAS: begin
            if (oidx < MAX_OUTPUTS)
               bias_mem[oidx] = value;
         end
         lrb_pkg::KIND_SAMPLE: begin
            if (feat < active_features && feat < MAX_FEATURES) begin
               diff = longint'(value) - longint'(median);
               for (int o = 0; o < n; o++)
                  acc_mem[o] = acc_mem[o]
                             + 48'(diff * longint'(weight_mem[feat * MAX_OUTPUTS + o]));
            end
            if (last) begin
               for (int o = 0; o < n; o++) begin
                  // arithmetic shift gives the floor toward minus infinity
                  sum = (longint'(acc_mem[o]) >>> 12) + longint'(bias_mem[o]);
                  if (sum < 0)
                     sum = 0;
                  else if (sum > longint'(lrb_pkg::PRED_MAX))
                     sum = longint'(lrb_pkg::PRED_MAX);
                  p.prediction      = 11'(sum);
                  p.regressor_index = 6'(o);
                  p.last_result     = (o == n - 1);
                  pending_predictions = {pending_predictions, p};
               end
               foreach (acc_mem[o]) acc_mem[o] = '0;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (acc_mem[o]) acc_mem[o] = '0;
         active_outputs  = lrb_pkg::ACTIVE_OUTPUTS_RESET;
         active_features = lrb_pkg::ACTIVE_FEATURES_RESET;
         pending_predictions.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_predictions.size() == 0) begin
               report_mismatch("unexpected prediction", rsp_prediction, -1);
            end else begin
               oldest = pending_predictions.pop_front();
               if (rsp_prediction !== oldest.prediction)
                  report_mismatch("prediction", rsp_prediction, oldest.prediction);
               if (rsp_regressor_index !== oldest.regressor_index)
                  report_mismatch("regressor index", rsp_regressor_index,
                                  oldest.regressor_index);
               if (rsp_last_result !== oldest.last_result)
                  report_mismatch("last result", rsp_last_result, oldest.last_result);
            end
         end
         if (csr_we) begin
            case (csr_index)
               lrb_pkg::CSR_ACTIVE_OUTPUTS:  active_outputs  = csr_wdata[6:0];
               lrb_pkg::CSR_ACTIVE_FEATURES: active_features = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy)
            predict_request(req_kind, req_feature_index, req_output_index, req_value,
                            req_median_value, req_last_element);
      end
      outstanding <= pending_predictions.size();
   end

endmodule

/* tb/sv/linear_regressor_bank_clamped_tb.sv */
module linear_regressor_bank_clamped_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FEATURES = 4096;
   localparam int MAX_OUTPUTS  = 16;
   // a full queue of used elements plus one whole emission
   localparam int DRAIN_CYCLES = 120;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_kind = lrb_pkg::KIND_WEIGHT;
   logic [11:0]        req_feature_index = '0;
   logic [5:0]         req_output_index = '0;
   logic signed [15:0] req_value = '0;
   logic signed [15:0] req_median_value = '0;
   logic               req_last_element = 1'b0;
   logic               rsp_valid;
   logic [10:0]        rsp_prediction;
   logic [5:0]         rsp_regressor_index;
   logic               rsp_last_result;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = lrb_pkg::CSR_ACTIVE_OUTPUTS;
   logic [12:0]        csr_wdata = '0;
   int                 errors;
   int                 outstanding;

   // what the stimulus may read without touching unwritten weights or biases
   bit [15:0] weights_known [0:MAX_FEATURES-1];
   bit [15:0] biases_known;
   bit        in_pool [0:MAX_FEATURES-1];
   int        feature_pool [$];
   int        n_out = 0;
   int        n_feat = 4096;
   bit        gaps_on = 1'b0;

   linear_regressor_bank_clamped #(
      .MAX_FEATURES(MAX_FEATURES),
      .MAX_OUTPUTS (MAX_OUTPUTS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_feature_index  (req_feature_index),
      .req_output_index   (req_output_index),
      .req_value          (req_value),
      .req_median_value   (req_median_value),
      .req_last_element   (req_last_element),
      .rsp_valid          (rsp_valid),
      .rsp_prediction     (rsp_prediction),
      .rsp_regressor_index(rsp_regressor_index),
      .rsp_last_result    (rsp_last_result),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   linear_regressor_bank_clamped_checker #(
      .MAX_FEATURES(MAX_FEATURES),
      .MAX_OUTPUTS (MAX_OUTPUTS)
   ) i_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_feature_index  (req_feature_index),
      .req_output_index   (req_output_index),
      .req_value          (req_value),
      .req_median_value   (req_median_value),
      .req_last_element   (req_last_element),
      .rsp_valid          (rsp_valid),
      .rsp_prediction     (rsp_prediction),
      .rsp_regressor_index(rsp_regressor_index),
      .rsp_last_result    (rsp_last_result),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .errors             (errors),
      .outstanding        (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [15:0] rand_weight();
      if ($urandom_range(0, 3) == 0)
         return 16'($urandom);
      return 16'(int'($urandom_range(0, 1023)) - 512);
   endfunction

   function automatic logic [15:0] rand_bias();
      if ($urandom_range(0, 3) == 0)
         return 16'($urandom);
      return 16'($urandom_range(0, 1400));
   endfunction

   task automatic send(logic [1:0] kind, int feat, int oidx, logic [15:0] value,
                       logic [15:0] median, bit last);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_kind          <= kind;
      req_feature_index <= 12'(feat);
      req_output_index  <= 6'(oidx);
      req_value         <= value;
      req_median_value  <= median;
      req_last_element  <= last;
      do @(posedge clock); while (busy);
      if (kind == lrb_pkg::KIND_WEIGHT && oidx < MAX_OUTPUTS)
         weights_known[feat][oidx] = 1'b1;
      if (kind == lrb_pkg::KIND_BIAS && oidx < MAX_OUTPUTS)
         biases_known[oidx] = 1'b1;
   endtask

   // wait for every prediction, then for loads still in the queue
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [12:0] outputs_word, logic [12:0] features_word);
      csr_we    <= 1'b1;
      csr_index <= lrb_pkg::CSR_ACTIVE_OUTPUTS;
      csr_wdata <= outputs_word;
      @(posedge clock);
      csr_index <= lrb_pkg::CSR_ACTIVE_FEATURES;
      csr_wdata <= features_word;
      @(posedge clock);
      csr_we <= 1'b0;
      n_out  = (outputs_word[6:0] > MAX_OUTPUTS) ? MAX_OUTPUTS : int'(outputs_word[6:0]);
      n_feat = int'(features_word);
   endtask

   // load whatever the active regressors and used features would read
   task automatic ensure_ready();
      int usable;
      int f;
      for (int o = 0; o < n_out; o++)
         if (!biases_known[o])
            send(lrb_pkg::KIND_BIAS, $urandom_range(0, 4095), o, rand_bias(), 16'($urandom),
                 1'($urandom));
      usable = 0;
      foreach (feature_pool[i]) if (feature_pool[i] < n_feat) usable++;
      while (usable < 3 && usable < n_feat) begin
         f = $urandom_range(0, n_feat - 1);
         if (!in_pool[f]) begin
            feature_pool = {feature_pool, f};
            in_pool[f] = 1'b1;
            usable++;
         end
      end
      foreach (feature_pool[i])
         if (feature_pool[i] < n_feat)
            for (int o = 0; o < n_out; o++)
               if (!weights_known[feature_pool[i]][o])
                  send(lrb_pkg::KIND_WEIGHT, feature_pool[i], o, rand_weight(),
                       16'($urandom), 1'($urandom));
   endtask

   task automatic send_descriptor(int len);
      int          usable [$];
      int          f;
      logic [15:0] value;
      logic [15:0] median;
      foreach (feature_pool[i])
         if (feature_pool[i] < n_feat) usable = {usable, feature_pool[i]};
      for (int i = 0; i < len; i++) begin
         if (n_feat < MAX_FEATURES && ($urandom_range(0, 4) == 0 || usable.size() == 0))
            f = $urandom_range(n_feat, MAX_FEATURES - 1);
         else
            f = usable[$urandom_range(0, usable.size() - 1)];
         value = 16'($urandom);
         // mostly near the median so that sums stay inside the clamp window
         if ($urandom_range(0, 3) == 0)
            median = 16'($urandom);
         else
            median = value + 16'($urandom_range(0, 255)) - 16'd128;
         send(lrb_pkg::KIND_SAMPLE, f, $urandom_range(0, 63), value, median, i == len - 1);
      end
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 4))
         0: send(KIND_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 63),
                 16'($urandom), 16'($urandom), 1'($urandom));
         1: send(lrb_pkg::KIND_WEIGHT, $urandom_range(0, 4095),
                 $urandom_range(MAX_OUTPUTS, 63), 16'($urandom), 16'($urandom),
                 1'($urandom));
         2: send(lrb_pkg::KIND_BIAS, $urandom_range(0, 4095),
                 $urandom_range(MAX_OUTPUTS, 63), 16'($urandom), 16'($urandom),
                 1'($urandom));
         3: send(lrb_pkg::KIND_WEIGHT,
                 feature_pool[$urandom_range(0, feature_pool.size() - 1)],
                 $urandom_range(0, MAX_OUTPUTS - 1), rand_weight(), 16'($urandom),
                 1'($urandom));
         default: send(lrb_pkg::KIND_BIAS, $urandom_range(0, 4095),
                       $urandom_range(0, MAX_OUTPUTS - 1), rand_bias(), 16'($urandom),
                       1'($urandom));
      endcase
   endtask

   task automatic run_phase(int count, bit allow_gaps);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) begin
            send_noise();
            sent++;
         end else begin
            len = $urandom_range(1, 6);
            send_descriptor(len);
            sent += len;
         end
      end
   endtask

   initial begin
      feature_pool = '{0, 4095};
      in_pool[0]    = 1'b1;
      in_pool[4095] = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // no regressors active after reset: loads and samples emit nothing
      send(lrb_pkg::KIND_WEIGHT, 0, 0, 16'h7fff, 16'h0000, 1'b0);
      send(lrb_pkg::KIND_WEIGHT, 4095, 15, 16'h8000, 16'hffff, 1'b1);
      send(lrb_pkg::KIND_BIAS, 0, 0, 16'h8000, 16'h0000, 1'b0);
      send(lrb_pkg::KIND_BIAS, 4095, 15, 16'h7fff, 16'h7fff, 1'b1);
      send(lrb_pkg::KIND_WEIGHT, 4095, 63, 16'hffff, 16'hffff, 1'b1);
      send(lrb_pkg::KIND_BIAS, 0, 16, 16'h1234, 16'h0000, 1'b0);
      send(KIND_UNUSED, 4095, 63, 16'hffff, 16'hffff, 1'b1);
      send(lrb_pkg::KIND_SAMPLE, 4095, 63, 16'h8000, 16'h7fff, 1'b0);
      send(lrb_pkg::KIND_SAMPLE, 0, 0, 16'h7fff, 16'h8000, 1'b1);
      settle();

      configure(13'd16, 13'd4096);
      ensure_ready();
      // extreme differences drive both clamp limits
      send(lrb_pkg::KIND_SAMPLE, 0, 0, 16'h7fff, 16'h8000, 1'b1);
      send(lrb_pkg::KIND_SAMPLE, 4095, 0, 16'h8000, 16'h7fff, 1'b1);
      send(lrb_pkg::KIND_SAMPLE, 4095, 0, 16'h0100, 16'h0100, 1'b1);
      run_phase(60, 1'b1);
      settle();

      configure(13'd64, 13'd1);
      ensure_ready();
      run_phase(35, 1'b1);
      settle();

      configure(13'd1, 13'($urandom_range(2, 40)));
      ensure_ready();
      run_phase(55, 1'b1);
      settle();

      // upper bits of the word are not part of the register
      configure(13'h1f80 | 13'($urandom_range(2, 15)), 13'($urandom_range(100, 4095)));
      ensure_ready();
      run_phase(55, 1'b1);
      settle();

      configure(13'd0, 13'($urandom_range(1, 4096)));
      ensure_ready();
      run_phase(30, 1'b1);
      settle();

      configure(13'd16, 13'd4096);
      ensure_ready();
      run_phase(75, 1'b0);
      settle();

      if (errors == 0)
         $display("linear_regressor_bank_clamped verification clean");
      else
         $display("linear_regressor_bank_clamped verification failed");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("linear_regressor_bank_clamped verification failed");
      $finish;
   end

endmodule
